// ----- rtl/binary_cross_entropy_loss_grad_assert.svh -----
// Assertion macros for the cross-entropy loss and gradient block.
`ifndef BINARY_CROSS_ENTROPY_LOSS_GRAD_ASSERT_SVH
`define BINARY_CROSS_ENTROPY_LOSS_GRAD_ASSERT_SVH

// Same-cycle implication on clk, off while rst is high.
`define BCEL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk, off while rst is high.
`define BCEL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bcel_pkg.sv -----
// Shared constants, types and the log2 table generator for the loss block.
`timescale 1ns / 1ps

package bcel_pkg;

  localparam int FRAC_BITS           = 16;
  localparam int MAX_ELEMENTS        = 1024;
  localparam int LOG_ENTRIES_DEFAULT = 256;

  // Field and datapath widths
  localparam int PROB_W  = 17;              // input probability, Q0.16 incl. 1.0
  localparam int P_W     = FRAC_BITS;       // clamped prediction, 1..65535
  localparam int N_W     = 11;              // element count / index
  localparam int SUM_W   = 32;              // running loss sum
  localparam int MAG_W   = 21;              // -log2 magnitude, Q5.16
  localparam int NL_W    = 20;              // -ln value, Q4.16
  localparam int ACC_W   = 36;              // y*(-ln) partial sums
  localparam int TERM_W  = 20;              // element loss
  localparam int DEN_W   = 41;              // p*(1-p)*n
  localparam int QUO_W   = 33;              // divider quotient bits
  localparam int GRAD_W  = 33;
  localparam int MEAN_W  = 20;
  localparam int MUL_A_W = 31;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  localparam int LN2_Q16    = 45426;
  localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

  localparam logic [PROB_W-1:0] PROB_ONE     = PROB_W'(1 << FRAC_BITS);
  localparam logic [GRAD_W-1:0] GRAD_POS_SAT = {1'b0, {(GRAD_W-1){1'b1}}};
  localparam logic [GRAD_W-1:0] GRAD_NEG_SAT = {1'b1, {(GRAD_W-1){1'b0}}};
  localparam logic [QUO_W-1:0]  QUO_NEG_LIM  = {1'b1, {(QUO_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEN_A,
    ST_DEN_B,
    ST_LN_P,
    ST_LN_P_RND,
    ST_TERM_P,
    ST_LN_Q,
    ST_LN_Q_RND,
    ST_TERM_Q,
    ST_ACC,
    ST_GRAD,
    ST_GRAD_WAIT,
    ST_MEAN,
    ST_MEAN_WAIT,
    ST_OUT
  } state_t;

  // log2(1 + i/2^ent_bits) in Q.FRAC_BITS by repeated squaring of a Q1.30 mantissa
  function automatic logic [FRAC_BITS-1:0] log_rom_entry(int unsigned i,
                                                         int unsigned ent_bits);
    logic [63:0]          x;
    logic [FRAC_BITS-1:0] r;
    x = ((64'd1 << ent_bits) + 64'(i)) << (30 - ent_bits);
    r = '0;
    for (int b = 1; b <= FRAC_BITS; b++) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        r[FRAC_BITS-b] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/binary_cross_entropy_loss_grad.sv -----
// Top level: binary cross-entropy loss and gradient over a stream of elements.
`timescale 1ns / 1ps
`include "binary_cross_entropy_loss_grad_assert.svh"

// Usage
//   Input stream: one request per element, a predicted probability and a target
//   probability, both Q0.16 with 65536 meaning 1.0. Output stream: one request per
//   element with the gradient (y_hat - y) / (y_hat (1 - y_hat)) / N as signed Q16.16,
//   saturated; tlast marks the N-th element, which also carries the mean loss
//   (Q4.16) of the vector. cfg_we/cfg_wdata write N; write it only while idle.
// Timing
//   One element at a time. The closing element of a vector also runs a divide for
//   the mean. An element whose gradient saturates skips the gradient divide. The
//   divider is a 33-step restoring divider; the registered multiplier and log unit
//   work in the states ahead of it.
// Reset
//   rst clears the running sum and the element index and sets N to 1.
// Stalls
//   A finished result sits in the output register; the next element is accepted and
//   worked on meanwhile, and the block holds in its final state until that register
//   frees up.

module binary_cross_entropy_loss_grad #(
  parameter int LOG_TABLE_ENTRIES = bcel_pkg::LOG_ENTRIES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bcel_pkg::N_W-1:0]          cfg_wdata,     // element_count
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [16:0] predicted_prob, [33:17] target_prob, [39:34] zero
  input  logic [bcel_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [32:0] gradient, [52:33] mean_loss, [55:53] zero
  output logic [bcel_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tlast   // loss_valid
);

  import bcel_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - GRAD_W - MEAN_W;

  state_t state;
  state_t state_next;

  // configuration and running state
  logic [N_W-1:0]   element_count;
  logic [SUM_W-1:0] loss_sum;
  logic [N_W-1:0]   element_index;

  // per-element operands, captured at accept
  logic [P_W-1:0]    p;
  logic [P_W-1:0]    pm;
  logic [PROB_W-1:0] y;
  logic [PROB_W-1:0] ym;
  logic              neg;
  logic [P_W-1:0]    gmag;
  logic [N_W-1:0]    n;
  logic              last;

  // intermediates
  logic [DEN_W-1:0]  den;
  logic [NL_W-1:0]   nl;
  logic [ACC_W-1:0]  acc;
  logic [GRAD_W-1:0] grad;
  logic [MEAN_W-1:0] mean;

  // accept-side clamping
  logic              s_accept;
  logic [PROB_W-1:0] p_in;
  logic [PROB_W-1:0] y_in;
  logic [P_W-1:0]    p_cl;
  logic [PROB_W-1:0] y_cl;
  logic [PROB_W-1:0] pm_full;
  logic [N_W-1:0]    n_cl;

  // shared units
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;
  logic               log_sel_q;
  logic [P_W-1:0]     log_x;
  logic [MAG_W-1:0]   log_mag;
  logic               div_start;
  logic               div_sel_mean;
  logic [DEN_W-1:0]   div_rem_init;
  logic [QUO_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_done;
  logic [QUO_W-1:0]   div_quot;

  // datapath helpers
  logic [ACC_W:0]     rnd;
  logic [ACC_W:0]     tsum;
  logic [SUM_W:0]     sum_ext;
  logic [SUM_W-1:0]   sum_sat;
  logic               grad_ovf;
  logic [GRAD_W-1:0]  grad_q;
  logic [MEAN_W-1:0]  mean_q;
  logic               out_load;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign p_in = s_axis_tdata[PROB_W-1:0];
  assign y_in = s_axis_tdata[2*PROB_W-1:PROB_W];

  // clamp prediction to 1..65535, target to at most 1.0, N to 1..MAX_ELEMENTS
  always_comb begin
    if (p_in == '0) begin
      p_cl = P_W'(1);
    end else if (p_in[PROB_W-1]) begin
      p_cl = '1;
    end else begin
      p_cl = p_in[P_W-1:0];
    end
    y_cl    = (y_in > PROB_ONE) ? PROB_ONE : y_in;
    pm_full = PROB_ONE - {1'b0, p_cl};
    if (element_count == '0) begin
      n_cl = N_W'(1);
    end else if (element_count > N_W'(MAX_ELEMENTS)) begin
      n_cl = N_W'(MAX_ELEMENTS);
    end else begin
      n_cl = element_count;
    end
  end

  bcel_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign log_x = log_sel_q ? pm : p;

  bcel_log #(
    .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
  ) u_log (
    .clk (clk),
    .x   (log_x),
    .mag (log_mag)
  );

  // gradient divide: (gmag << 32) / den, split as a remainder seed and 33 low bits;
  // mean divide: loss_sum / n
  assign div_rem_init = div_sel_mean ? '0 : DEN_W'(gmag[P_W-1:1]);
  assign div_num      = div_sel_mean ? QUO_W'(loss_sum) : {gmag[0], (QUO_W-1)'(0)};
  assign div_den      = div_sel_mean ? DEN_W'(n) : den;

  bcel_div #(
    .REM_W (DEN_W),
    .Q_W   (QUO_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem_init),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_comb begin
    rnd     = {1'b0, prod[ACC_W-1:0]} + (ACC_W+1)'(ROUND_HALF);
    tsum    = {1'b0, acc} + {1'b0, prod[ACC_W-1:0]};
    sum_ext = {1'b0, loss_sum} + (SUM_W+1)'(tsum[FRAC_BITS +: TERM_W]);
    sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    // quotient would reach 2^33: skip the divide and saturate
    grad_ovf = (DEN_W+1)'(gmag) >= {den, 1'b0};
    if (neg) begin
      grad_q = (div_quot > QUO_NEG_LIM) ? GRAD_NEG_SAT : (GRAD_W'(0) - div_quot);
    end else begin
      grad_q = div_quot[QUO_W-1] ? GRAD_POS_SAT : div_quot;
    end
    mean_q = (|div_quot[QUO_W-1:MEAN_W]) ? '1 : div_quot[MEAN_W-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    mul_a        = '0;
    mul_b        = '0;
    log_sel_q    = 1'b0;
    div_start    = 1'b0;
    div_sel_mean = 1'b0;
    out_load     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = ST_DEN_A;
        end
      end
      ST_DEN_A: begin
        mul_a      = MUL_A_W'(p);
        mul_b      = MUL_B_W'(pm);
        state_next = ST_DEN_B;
      end
      ST_DEN_B: begin
        mul_a      = prod[MUL_A_W-1:0];
        mul_b      = MUL_B_W'(n);
        state_next = ST_LN_P;
      end
      ST_LN_P: begin
        mul_a      = MUL_A_W'(log_mag);
        mul_b      = MUL_B_W'(LN2_Q16);
        state_next = ST_LN_P_RND;
      end
      ST_LN_P_RND: begin
        log_sel_q  = 1'b1;
        state_next = ST_TERM_P;
      end
      ST_TERM_P: begin
        log_sel_q  = 1'b1;
        mul_a      = MUL_A_W'(nl);
        mul_b      = y;
        state_next = ST_LN_Q;
      end
      ST_LN_Q: begin
        mul_a      = MUL_A_W'(log_mag);
        mul_b      = MUL_B_W'(LN2_Q16);
        state_next = ST_LN_Q_RND;
      end
      ST_LN_Q_RND: begin
        state_next = ST_TERM_Q;
      end
      ST_TERM_Q: begin
        mul_a      = MUL_A_W'(nl);
        mul_b      = ym;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        state_next = ST_GRAD;
      end
      ST_GRAD: begin
        if (grad_ovf) begin
          state_next = last ? ST_MEAN : ST_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_GRAD_WAIT;
        end
      end
      ST_GRAD_WAIT: begin
        if (div_done) begin
          state_next = last ? ST_MEAN : ST_OUT;
        end
      end
      ST_MEAN: begin
        div_start    = 1'b1;
        div_sel_mean = 1'b1;
        state_next   = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_accept) begin
      p    <= p_cl;
      pm   <= pm_full[P_W-1:0];
      y    <= y_cl;
      ym   <= PROB_ONE - y_cl;
      neg  <= y_cl > {1'b0, p_cl};
      gmag <= (y_cl > {1'b0, p_cl}) ? P_W'(y_cl - {1'b0, p_cl})
                                    : P_W'({1'b0, p_cl} - y_cl);
      n    <= n_cl;
      last <= ({1'b0, element_index} + 1'b1) >= {1'b0, n_cl};
    end
    case (state) inside
      ST_LN_P: begin
        den <= prod[DEN_W-1:0];
      end
      ST_LN_P_RND, ST_LN_Q_RND: begin
        nl <= rnd[FRAC_BITS +: NL_W];
      end
      ST_LN_Q: begin
        acc <= prod[ACC_W-1:0];
      end
      ST_GRAD: begin
        if (grad_ovf) begin
          grad <= neg ? GRAD_NEG_SAT : GRAD_POS_SAT;
        end
      end
      ST_GRAD_WAIT: begin
        if (div_done) begin
          grad <= grad_q;
        end
      end
      ST_MEAN_WAIT: begin
        if (div_done) begin
          mean <= mean_q;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      m_axis_tdata <= {PAD_W'(0), (last ? mean : MEAN_W'(0)), grad};
      m_axis_tlast <= last;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= N_W'(1);
      loss_sum      <= '0;
      element_index <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        element_count <= cfg_wdata;
      end
      if (state == ST_ACC) begin
        loss_sum <= sum_sat;
      end
      if (out_load) begin
        // close the vector: drop the sum and restart the count
        if (last) begin
          loss_sum      <= '0;
          element_index <= '0;
        end else begin
          element_index <= element_index + 1'b1;
        end
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  `BCEL_ASSERT_NOW(a_div_done_in_wait, div_done, state == ST_GRAD_WAIT || state == ST_MEAN_WAIT, "divider finished outside a wait state")
  `BCEL_ASSERT_NEXT(a_busy_after_accept, s_accept, !s_axis_tready && state == ST_DEN_A, "block still ready after taking a request")
  `BCEL_ASSERT_NOW(a_index_clear_on_close, m_axis_tvalid && m_axis_tlast, element_index == '0, "element index not cleared after closing a vector")

endmodule

// ----- rtl/bcel_mul.sv -----
// Registered shared multiplier.
`timescale 1ns / 1ps

module bcel_mul #(
  parameter int A_W = bcel_pkg::MUL_A_W,
  parameter int B_W = bcel_pkg::MUL_B_W
) (
  input  logic                 clk,
  input  logic [A_W-1:0]       a,
  input  logic [B_W-1:0]       b,
  output logic [A_W+B_W-1:0]   p
);

  localparam int PROD_W = A_W + B_W;

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// ----- rtl/bcel_log.sv -----
// Registered -log2 magnitude: leading-one search plus fraction table.
`timescale 1ns / 1ps

module bcel_log #(
  parameter int LOG_TABLE_ENTRIES = bcel_pkg::LOG_ENTRIES_DEFAULT
) (
  input  logic                      clk,
  input  logic [bcel_pkg::P_W-1:0]  x,
  output logic [bcel_pkg::MAG_W-1:0] mag
);

  import bcel_pkg::*;

  localparam int ENT_BITS = $clog2(LOG_TABLE_ENTRIES);
  localparam int K_W      = $clog2(P_W);

  logic [FRAC_BITS-1:0] rom [LOG_TABLE_ENTRIES];
  logic [K_W-1:0]       lead;
  logic [K_W:0]         whole;
  logic [P_W-1:0]       norm;
  logic [ENT_BITS-1:0]  idx;

  for (genvar gi = 0; gi < LOG_TABLE_ENTRIES; gi++) begin : g_rom
    localparam logic [FRAC_BITS-1:0] ENTRY = log_rom_entry(gi, ENT_BITS);
    assign rom[gi] = ENTRY;
  end

  always_comb begin
    lead = '0;
    for (int i = 0; i < P_W; i++) begin
      if (x[i]) begin
        lead = K_W'(i);
      end
    end
    // normalize so the leading one sits at the top bit; table index is the next bits
    norm  = x << (K_W'(P_W - 1) - lead);
    idx   = norm[P_W-2 -: ENT_BITS];
    whole = (K_W+1)'(P_W) - {1'b0, lead};
  end

  always_ff @(posedge clk) begin
    mag <= {whole, FRAC_BITS'(0)} - MAG_W'(rom[idx]);
  end

endmodule

// ----- rtl/bcel_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bcel_div #(
  parameter int REM_W = bcel_pkg::DEN_W,
  parameter int Q_W   = bcel_pkg::QUO_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [REM_W-1:0] rem_init,
  input  logic [Q_W-1:0]   num,
  input  logic [REM_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quot
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] den_q;
  logic [Q_W-1:0]   shreg;
  logic [REM_W:0]   trial;

  // rem < den always holds, so the borrow shows in the top bit
  assign trial = {rem, shreg[Q_W-1]} - {1'b0, den_q};
  assign quot  = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(Q_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      den_q <= den;
      shreg <= num;
    end else if (cnt != '0) begin
      if (!trial[REM_W]) begin
        rem   <= trial[REM_W-1:0];
        shreg <= {shreg[Q_W-2:0], 1'b1};
      end else begin
        rem   <= {rem[REM_W-2:0], shreg[Q_W-1]};
        shreg <= {shreg[Q_W-2:0], 1'b0};
      end
    end
  end

endmodule
